>>> hw/rtl/envp_pkg.sv
`timescale 1ns / 1ps
// Package for the envelope header parser: item types, header layout constants
// and the queue entry passed from the front end to the back end. No dependencies.
package envp_pkg;

  localparam int unsigned HDR_LEN       = 17;
  localparam int unsigned HDR_POS_W     = 5;
  localparam int unsigned VER_POS       = 4;
  localparam int unsigned REV_FIRST_POS = 5;
  localparam int unsigned REV_LAST_POS  = 12;

  localparam logic [7:0] MAGIC_0     = 8'h58; // 'X'
  localparam logic [7:0] MAGIC_1     = 8'h4E; // 'N'
  localparam logic [7:0] MAGIC_2     = 8'h53; // 'S'
  localparam logic [7:0] MAGIC_3     = 8'h50; // 'P'
  localparam logic [7:0] VERSION_ONE = 8'h01;

  localparam logic [31:0] MAX_PAYLOAD_RESET = 32'd65536;

  localparam int unsigned PAY_CNT_W = 33;

  localparam int unsigned FIFO_DEPTH = 2;
  localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } envp_in_t;

  typedef struct packed {
    logic [7:0]  payload_byte;
    logic        payload_valid;
    logic        frame_done;
    logic        corrupt;
    logic [63:0] revision_out;
  } envp_out_t;

  // One classified byte on its way to the back end.
  typedef struct packed {
    logic [7:0]           data;
    logic                 payload;
    logic                 last;
    logic                 hdr_bad;
    logic [63:0]          revision;
    logic [31:0]          length;
    logic [PAY_CNT_W-1:0] pay_count;
  } envp_entry_t;

endpackage

>>> hw/rtl/envp_front.sv
`timescale 1ns / 1ps
// Front end of the envelope header parser: accepts bytes, checks and decodes
// the header and classifies each byte into a queue entry. Uses envp_pkg.
module envp_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 byte_valid,
  input  envp_pkg::envp_in_t   byte_item,
  input  logic                 q_full,
  output logic                 byte_stall,
  output logic                 q_push,
  output envp_pkg::envp_entry_t q_data
);
  import envp_pkg::*;

  logic [HDR_POS_W-1:0] hdr_pos;
  logic [HDR_POS_W-1:0] hdr_pos_next;
  logic                 header_bad;
  logic                 header_bad_next;
  logic [63:0]          revision_acc;
  logic [63:0]          revision_acc_next;
  logic [31:0]          length_acc;
  logic [31:0]          length_acc_next;
  logic [PAY_CNT_W-1:0] pay_cnt;
  logic [PAY_CNT_W-1:0] pay_cnt_next;
  logic                 accept;
  logic                 is_payload;
  logic                 is_short;
  logic [7:0]           b;

  assign byte_stall = q_full;
  assign accept     = byte_valid && !q_full;
  assign b          = byte_item.in_byte;
  assign is_payload = (hdr_pos == HDR_POS_W'(HDR_LEN));
  // A header byte that ends the envelope leaves it short unless it is the
  // final header byte.
  assign is_short   = !is_payload && (hdr_pos != HDR_POS_W'(HDR_LEN - 1));

  always_comb begin
    header_bad_next   = header_bad;
    revision_acc_next = revision_acc;
    length_acc_next   = length_acc;
    hdr_pos_next      = hdr_pos;
    pay_cnt_next      = pay_cnt;
    if (is_payload) begin
      // Bit 32 set means at least 2^32 payload bytes; the count sticks there.
      if (!pay_cnt[PAY_CNT_W-1]) begin
        pay_cnt_next = pay_cnt + PAY_CNT_W'(1);
      end
    end else begin
      hdr_pos_next = hdr_pos + HDR_POS_W'(1);
      priority if (hdr_pos == HDR_POS_W'(0)) begin
        if (b != MAGIC_0) header_bad_next = 1'b1;
      end else if (hdr_pos == HDR_POS_W'(1)) begin
        if (b != MAGIC_1) header_bad_next = 1'b1;
      end else if (hdr_pos == HDR_POS_W'(2)) begin
        if (b != MAGIC_2) header_bad_next = 1'b1;
      end else if (hdr_pos == HDR_POS_W'(3)) begin
        if (b != MAGIC_3) header_bad_next = 1'b1;
      end else if (hdr_pos == HDR_POS_W'(VER_POS)) begin
        if (b != VERSION_ONE) header_bad_next = 1'b1;
      end else if (hdr_pos <= HDR_POS_W'(REV_LAST_POS)) begin
        revision_acc_next = {revision_acc[55:0], b};
      end else begin
        length_acc_next = {length_acc[23:0], b};
      end
    end
  end

  always_comb begin
    q_push           = accept && (is_payload || byte_item.in_last);
    q_data.data      = is_payload ? b : 8'd0;
    q_data.payload   = is_payload;
    q_data.last      = byte_item.in_last;
    q_data.hdr_bad   = header_bad_next || is_short;
    q_data.revision  = revision_acc_next;
    q_data.length    = length_acc_next;
    q_data.pay_count = is_payload ? pay_cnt_next : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hdr_pos      <= '0;
      header_bad   <= 1'b0;
      revision_acc <= '0;
      length_acc   <= '0;
      pay_cnt      <= '0;
    end else if (accept) begin
      if (byte_item.in_last) begin
        hdr_pos      <= '0;
        header_bad   <= 1'b0;
        revision_acc <= '0;
        length_acc   <= '0;
        pay_cnt      <= '0;
      end else begin
        hdr_pos      <= hdr_pos_next;
        header_bad   <= header_bad_next;
        revision_acc <= revision_acc_next;
        length_acc   <= length_acc_next;
        pay_cnt      <= pay_cnt_next;
      end
    end
  end

  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    hdr_pos <= HDR_POS_W'(HDR_LEN))
    else $error("header position ran past the header length");

  a_last_clears: assert property (@(posedge clk) disable iff (rst)
    accept && byte_item.in_last |=> hdr_pos == '0 && pay_cnt == '0)
    else $error("envelope state not cleared after the last byte");

endmodule

>>> hw/rtl/envp_fifo.sv
`timescale 1ns / 1ps
// Short queue between the front and back ends of the envelope header parser.
// Holds classified entries; uses envp_pkg for the entry type and depth.
module envp_fifo (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  envp_pkg::envp_entry_t push_data,
  input  logic                  pop,
  output logic                  full,
  output logic                  not_empty,
  output envp_pkg::envp_entry_t pop_data
);
  import envp_pkg::*;

  envp_entry_t        mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr;
  logic [FIFO_AW-1:0] rd_ptr;
  logic [FIFO_AW:0]   count;
  logic               do_push;
  logic               do_pop;

  assign full      = (count == (FIFO_AW + 1)'(FIFO_DEPTH));
  assign not_empty = (count != '0);
  assign pop_data  = mem[rd_ptr];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + FIFO_AW'(1);
      if (do_pop)  rd_ptr <= rd_ptr + FIFO_AW'(1);
      unique case ({do_push, do_pop})
        2'b10:   count <= count + (FIFO_AW + 1)'(1);
        2'b01:   count <= count - (FIFO_AW + 1)'(1);
        default: count <= count;
      endcase
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= (FIFO_AW + 1)'(FIFO_DEPTH))
    else $error("queue count exceeds its depth");

  a_no_lost_push: assert property (@(posedge clk) disable iff (rst)
    push && full && !pop |=> full)
    else $error("queue lost its fill level after a refused push");

endmodule

>>> hw/rtl/envp_back.sv
`timescale 1ns / 1ps
// Back end of the envelope header parser: holds the payload limit register,
// judges finished envelopes and drives the output register. Uses envp_pkg.
module envp_back (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [31:0]           cfg_wdata,
  input  logic                  q_not_empty,
  input  envp_pkg::envp_entry_t q_data,
  output logic                  q_pop,
  input  logic                  result_stall,
  output logic                  result_valid,
  output envp_pkg::envp_out_t   result_item
);
  import envp_pkg::*;

  logic [31:0] max_payload;
  logic        corrupt_calc;
  envp_out_t   result_next;

  assign q_pop = q_not_empty && (!result_valid || !result_stall);

  always_comb begin
    corrupt_calc = q_data.hdr_bad
                || (q_data.revision == 64'd0)
                || (q_data.pay_count != {1'b0, q_data.length})
                || (q_data.pay_count > {1'b0, max_payload});
    result_next.payload_byte  = q_data.data;
    result_next.payload_valid = q_data.payload;
    result_next.frame_done    = q_data.last;
    result_next.corrupt       = q_data.last && corrupt_calc;
    result_next.revision_out  = q_data.last ? q_data.revision : 64'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_payload <= MAX_PAYLOAD_RESET;
    end else if (cfg_we) begin
      max_payload <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (q_pop) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      result_item <= result_next;
    end
  end

  a_mid_frame_clean: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_item.frame_done |->
      !result_item.corrupt && result_item.revision_out == 64'd0)
    else $error("mid-envelope item carries a verdict or revision");

endmodule

>>> hw/rtl/envelope_header_parser.sv
`timescale 1ns / 1ps
// Top level of the envelope header parser: front end, queue and back end.
// Depends on envp_pkg, envp_front, envp_fifo and envp_back.
//
//   channel   direction   handshake                  payload
//   byte      in          byte_valid / byte_stall    byte_item   (envp_in_t)
//   result    out         result_valid / result_stall result_item (envp_out_t)
//   cfg       in          cfg_we                     cfg_wdata   (max payload bytes)
//
// One byte item is taken every cycle while the two-entry queue has room.
// An accepted byte is written into the queue and then loaded from it into the
// output register, where it is presented as a result. Header bytes other
// than a last byte make no result.
// Reset is synchronous and clears the envelope state, the queue and the output valid.
// A stalled result holds in the output register; the queue absorbs two more items
// before byte_stall rises, so the front end keeps running while the consumer waits.
module envelope_header_parser (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 byte_valid,
  output logic                 byte_stall,
  input  envp_pkg::envp_in_t   byte_item,
  output logic                 result_valid,
  input  logic                 result_stall,
  output envp_pkg::envp_out_t  result_item,
  input  logic                 cfg_we,
  input  logic [31:0]          cfg_wdata
);
  import envp_pkg::*;

  // Classified entries travel from the front end through the queue.
  envp_entry_t front_entry;
  envp_entry_t back_entry;
  logic        q_push;
  logic        q_pop;
  logic        q_full;
  logic        q_not_empty;

  // The front end walks the 17 header bytes, checks the magic and version,
  // shifts in the revision and length, and counts payload bytes. It pushes
  // an entry for every payload byte and for the last byte of an envelope.
  envp_front u_front (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .byte_item  (byte_item),
    .q_full     (q_full),
    .byte_stall (byte_stall),
    .q_push     (q_push),
    .q_data     (front_entry)
  );

  // The queue decouples the two halves so that a stalled consumer does not
  // stop byte intake at once.
  envp_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (front_entry),
    .pop       (q_pop),
    .full      (q_full),
    .not_empty (q_not_empty),
    .pop_data  (back_entry)
  );

  // The back end makes the final verdict on the last byte: a bad header,
  // a short envelope, a zero revision, a length mismatch or a payload over
  // the configured limit all mark the envelope corrupt.
  envp_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .q_not_empty  (q_not_empty),
    .q_data       (back_entry),
    .q_pop        (q_pop),
    .result_stall (result_stall),
    .result_valid (result_valid),
    .result_item  (result_item)
  );

endmodule
